[rtl/gdfw_pkg.sv]
// gdfw_pkg: shared types and codes for the depth-first graph walker
// holds the transaction payload structs, action and result codes, defaults
// no dependencies
package gdfw_pkg;

    localparam int DEF_MAX_VERTICES = 16;
    localparam int DEF_MAX_DEGREE   = 16;

    // a search never gives more results than this
    localparam logic [4:0] RESULT_LIMIT = 5'd16;

    localparam logic [4:0] NUM_VERTICES_RESET = 5'd16;

    // action codes
    localparam logic [1:0] ACT_CLEAR  = 2'd0;
    localparam logic [1:0] ACT_ADD    = 2'd1;
    localparam logic [1:0] ACT_SEARCH = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_DONE  = 2'd0;
    localparam logic [1:0] KIND_VISIT = 2'd1;
    localparam logic [1:0] KIND_RANGE = 2'd2;
    localparam logic [1:0] KIND_FULL  = 2'd3;

    typedef struct packed {
        logic [1:0] action;
        logic [3:0] first_vertex;
        logic [3:0] second_vertex;
    } item_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [3:0] vertex;
        logic       last;
    } result_t;

endpackage

[rtl/graph_depth_first_walker_unit.sv]
// graph_depth_first_walker_unit: top level of the depth-first graph walker
// depends on gdfw_pkg (types, codes) and gdfw_ram (neighbour store, walk stack)
// the one configuration register, num_vertices, sits here
module graph_depth_first_walker_unit
    import gdfw_pkg::*;
#(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES,
    parameter int MAX_DEGREE   = DEF_MAX_DEGREE
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [4:0] cfg_data,
    input  logic       item_valid,
    output logic       item_ready,
    input  item_t      item,
    output logic       result_valid,
    input  logic       result_ready,
    output result_t    result
);

    // The walker keeps an undirected graph as per-vertex neighbour lists in a
    // synchronous ram (MAX_VERTICES x MAX_DEGREE entries), with list lengths
    // and visited marks in flip-flops that reset and a clear transaction wipe
    // at once, so no clearing pass is needed. One item is worked on at a
    // time. A clear, an unused action or a range error goes from the command
    // state to the response state; an edge add passes both append states
    // before the response, or leaves the first one for the response when a
    // list is full. A search starts in the command state, then uses a step
    // and a read state for every stored neighbour entry it tries (the
    // neighbour ram has one read port and a registered read) and a step and a
    // pop state for every backtrack (the walk stack ram reads the same way),
    // and the final result leaves from the flush state. Response, flush,
    // and a read that finds a new vertex wait while the result side holds
    // back a waiting result. Each visited vertex is held one step in a
    // pending register so that the last result can be flagged when the walk
    // ends. The output register lets the next item in while the final result
    // still waits to be taken. Configuration writes are always taken; the
    // count saturates at MAX_VERTICES, and zero flags every vertex.

    localparam int VW   = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CW   = $clog2(MAX_DEGREE + 1);
    localparam int CW1  = CW + 1;
    localparam int DPW  = $clog2(MAX_VERTICES + 1);
    localparam int NW   = $clog2(MAX_VERTICES + 1);
    localparam int CMPW = (NW > 5) ? NW : 5;
    localparam int NDEP = MAX_VERTICES * MAX_DEGREE;
    localparam int AW   = $clog2(NDEP);
    localparam int SAW  = $clog2(MAX_VERTICES);
    localparam int SW   = VW + CW;

    // sequencer states
    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_CMD    = 4'd1;
    localparam logic [3:0] ST_ADD_B  = 4'd2;
    localparam logic [3:0] ST_ADD_W2 = 4'd3;
    localparam logic [3:0] ST_RESP   = 4'd4;
    localparam logic [3:0] ST_STEP   = 4'd5;
    localparam logic [3:0] ST_READ   = 4'd6;
    localparam logic [3:0] ST_POP    = 4'd7;
    localparam logic [3:0] ST_FLUSH  = 4'd8;

    // neighbour store address of entry p of vertex v
    function automatic logic [AW-1:0] nbr_addr(input logic [VW-1:0] v,
                                               input logic [CW-1:0] p);
        nbr_addr = AW'(AW'(v) * AW'(MAX_DEGREE) + AW'(p));
    endfunction

    // registers
    logic [3:0]    state_reg, state_next;
    logic [4:0]    num_vertices_reg;
    item_t         item_reg;
    logic [1:0]    resp_kind_reg, resp_kind_next;
    logic [CW-1:0] ca_reg, ca_next;
    logic [CW-1:0] count_reg [MAX_VERTICES];
    logic [CW-1:0] count_next [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] visited_reg, visited_next;
    logic [VW-1:0] top_vertex_reg, top_vertex_next;
    logic [CW-1:0] top_pos_reg, top_pos_next;
    logic [DPW-1:0] depth_reg, depth_next;
    logic [4:0]    cnt_reg, cnt_next;
    logic [VW-1:0] pend_vertex_reg, pend_vertex_next;
    logic          result_valid_reg, result_valid_next;
    result_t       result_reg, result_next;

    // ram ports
    logic          nbr_wr_en, nbr_rd_en;
    logic [AW-1:0] nbr_wr_addr, nbr_rd_addr;
    logic [VW-1:0] nbr_wr_data, nbr_rd_data;
    logic          stk_wr_en, stk_rd_en;
    logic [SAW-1:0] stk_wr_addr, stk_rd_addr;
    logic [SW-1:0] stk_wr_data, stk_rd_data;

    // decode helpers
    logic [VW-1:0]   a_v, b_v, w_v, cnt_rd_idx;
    logic [CW-1:0]   cnt_rd;
    logic [CMPW-1:0] n_use, cfg_ext;
    logic            a_ok, b_ok, room, out_free;
    logic [DPW-1:0]  stk_push_idx, stk_pop_idx;

    assign cfg_ready    = 1'b1;
    assign item_ready   = (state_reg == ST_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    assign a_v = VW'(item_reg.first_vertex);
    assign b_v = VW'(item_reg.second_vertex);
    assign w_v = nbr_rd_data;

    // count in use saturates at MAX_VERTICES
    assign cfg_ext = CMPW'(num_vertices_reg);
    assign n_use   = (cfg_ext > CMPW'(MAX_VERTICES)) ? CMPW'(MAX_VERTICES) : cfg_ext;
    assign a_ok    = CMPW'(item_reg.first_vertex) < n_use;
    assign b_ok    = CMPW'(item_reg.second_vertex) < n_use;

    assign out_free = !result_valid_reg || result_ready;

    // single read port on the list lengths
    always_comb
    begin
        case (state_reg)
            ST_CMD:    cnt_rd_idx = a_v;
            ST_ADD_B:  cnt_rd_idx = b_v;
            ST_ADD_W2: cnt_rd_idx = b_v;
            default:   cnt_rd_idx = w_v;
        endcase
    end
    assign cnt_rd = count_reg[cnt_rd_idx];

    // a self-loop needs two free slots, a plain edge one at each end
    always_comb
    begin
        if (a_v == b_v)
        begin
            room = (CW1'(ca_reg) + CW1'(2)) <= CW1'(MAX_DEGREE);
        end
        else
        begin
            room = (ca_reg < CW'(MAX_DEGREE)) && (cnt_rd < CW'(MAX_DEGREE));
        end
    end

    assign stk_push_idx = depth_reg - DPW'(1);
    assign stk_pop_idx  = depth_reg - DPW'(2);

    // main sequencer
    always_comb
    begin
        state_next        = state_reg;
        resp_kind_next    = resp_kind_reg;
        ca_next           = ca_reg;
        count_next        = count_reg;
        visited_next      = visited_reg;
        top_vertex_next   = top_vertex_reg;
        top_pos_next      = top_pos_reg;
        depth_next        = depth_reg;
        cnt_next          = cnt_reg;
        pend_vertex_next  = pend_vertex_reg;
        result_valid_next = result_valid_reg && !result_ready;
        result_next       = result_reg;

        nbr_wr_en   = 1'b0;
        nbr_wr_addr = nbr_addr(a_v, ca_reg);
        nbr_wr_data = b_v;
        nbr_rd_en   = 1'b0;
        nbr_rd_addr = nbr_addr(top_vertex_reg, top_pos_reg - CW'(1));
        stk_wr_en   = 1'b0;
        stk_wr_addr = stk_push_idx[SAW-1:0];
        stk_wr_data = {top_vertex_reg, top_pos_reg};
        stk_rd_en   = 1'b0;
        stk_rd_addr = stk_pop_idx[SAW-1:0];

        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = ST_CMD;
                end
            end

            ST_CMD:
            begin
                case (item_reg.action)
                    ACT_CLEAR:
                    begin
                        for (int i = 0; i < MAX_VERTICES; i++)
                        begin
                            count_next[i] = '0;
                        end
                        visited_next   = '0;
                        resp_kind_next = KIND_DONE;
                        state_next     = ST_RESP;
                    end
                    ACT_ADD:
                    begin
                        if (!a_ok || !b_ok)
                        begin
                            resp_kind_next = KIND_RANGE;
                            state_next     = ST_RESP;
                        end
                        else
                        begin
                            ca_next    = cnt_rd;
                            state_next = ST_ADD_B;
                        end
                    end
                    ACT_SEARCH:
                    begin
                        if (!a_ok)
                        begin
                            resp_kind_next = KIND_RANGE;
                            state_next     = ST_RESP;
                        end
                        else
                        begin
                            // start vertex is always marked and reported
                            visited_next[a_v] = 1'b1;
                            pend_vertex_next  = a_v;
                            top_vertex_next   = a_v;
                            top_pos_next      = cnt_rd;
                            depth_next        = DPW'(1);
                            cnt_next          = 5'd1;
                            state_next        = ST_STEP;
                        end
                    end
                    default:
                    begin
                        resp_kind_next = KIND_DONE;
                        state_next     = ST_RESP;
                    end
                endcase
            end

            ST_ADD_B:
            begin
                if (!room)
                begin
                    resp_kind_next = KIND_FULL;
                    state_next     = ST_RESP;
                end
                else
                begin
                    nbr_wr_en       = 1'b1;
                    count_next[a_v] = ca_reg + CW'(1);
                    state_next      = ST_ADD_W2;
                end
            end

            ST_ADD_W2:
            begin
                // length read here already includes the first append
                nbr_wr_en       = 1'b1;
                nbr_wr_addr     = nbr_addr(b_v, cnt_rd);
                nbr_wr_data     = a_v;
                count_next[b_v] = cnt_rd + CW'(1);
                resp_kind_next  = KIND_DONE;
                state_next      = ST_RESP;
            end

            ST_RESP:
            begin
                if (out_free)
                begin
                    result_valid_next = 1'b1;
                    result_next       = '{kind: resp_kind_reg, vertex: 4'd0, last: 1'b1};
                    state_next        = ST_IDLE;
                end
            end

            ST_STEP:
            begin
                if (cnt_reg >= RESULT_LIMIT)
                begin
                    state_next = ST_FLUSH;
                end
                else if (top_pos_reg == '0)
                begin
                    // list exhausted, backtrack
                    depth_next = stk_push_idx;
                    if (depth_reg == DPW'(1))
                    begin
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        stk_rd_en  = 1'b1;
                        state_next = ST_POP;
                    end
                end
                else
                begin
                    // newest edge first
                    top_pos_next = top_pos_reg - CW'(1);
                    nbr_rd_en    = 1'b1;
                    state_next   = ST_READ;
                end
            end

            ST_READ:
            begin
                if (visited_reg[w_v])
                begin
                    state_next = ST_STEP;
                end
                else if (out_free)
                begin
                    // pending vertex goes out, new one waits for its last flag
                    result_valid_next = 1'b1;
                    result_next       = '{kind: KIND_VISIT, vertex: 4'(pend_vertex_reg),
                                          last: 1'b0};
                    pend_vertex_next  = w_v;
                    visited_next[w_v] = 1'b1;
                    cnt_next          = cnt_reg + 5'd1;
                    if (depth_reg < DPW'(MAX_VERTICES))
                    begin
                        stk_wr_en       = 1'b1;
                        top_vertex_next = w_v;
                        top_pos_next    = cnt_rd;
                        depth_next      = depth_reg + DPW'(1);
                    end
                    state_next = ST_STEP;
                end
            end

            ST_POP:
            begin
                {top_vertex_next, top_pos_next} = stk_rd_data;
                state_next = ST_STEP;
            end

            ST_FLUSH:
            begin
                if (out_free)
                begin
                    result_valid_next = 1'b1;
                    result_next       = '{kind: KIND_VISIT, vertex: 4'(pend_vertex_reg),
                                          last: 1'b1};
                    depth_next        = '0;
                    state_next        = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            num_vertices_reg <= NUM_VERTICES_RESET;
            visited_reg      <= '0;
            depth_reg        <= '0;
            cnt_reg          <= '0;
            result_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_VERTICES; i++)
            begin
                count_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg        <= state_next;
            visited_reg      <= visited_next;
            depth_reg        <= depth_next;
            cnt_reg          <= cnt_next;
            result_valid_reg <= result_valid_next;
            count_reg        <= count_next;
            if (cfg_valid && cfg_ready)
            begin
                num_vertices_reg <= cfg_data;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            item_reg <= item;
        end
        resp_kind_reg   <= resp_kind_next;
        ca_reg          <= ca_next;
        top_vertex_reg  <= top_vertex_next;
        top_pos_reg     <= top_pos_next;
        pend_vertex_reg <= pend_vertex_next;
        result_reg      <= result_next;
    end

    // neighbour lists, one row of MAX_DEGREE entries per vertex
    gdfw_ram #(
        .WIDTH (VW),
        .DEPTH (NDEP)
    ) u_nbr_ram (
        .clk     (clk),
        .wr_en   (nbr_wr_en),
        .wr_addr (nbr_wr_addr),
        .wr_data (nbr_wr_data),
        .rd_en   (nbr_rd_en),
        .rd_addr (nbr_rd_addr),
        .rd_data (nbr_rd_data)
    );

    // walk stack below the top entry; top lives in registers, a push and
    // the pop of the same slot always fall in different cycles
    gdfw_ram #(
        .WIDTH (SW),
        .DEPTH (MAX_VERTICES)
    ) u_stk_ram (
        .clk     (clk),
        .wr_en   (stk_wr_en),
        .wr_addr (stk_wr_addr),
        .wr_data (stk_wr_data),
        .rd_en   (stk_rd_en),
        .rd_addr (stk_rd_addr),
        .rd_data (stk_rd_data)
    );

endmodule

[rtl/gdfw_ram.sv]
// gdfw_ram: generic simple dual-port ram, one write and one registered read
// no dependencies
module gdfw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        // read data holds until the next read
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
